/* src/itx4_pkg.sv */
// Package for the 4-point inverse transform: field widths, payload types,
// register indexes and the configuration bundle. No dependencies.
package itx4_pkg;

  localparam int COEF_W     = 16;
  localparam int RES_W      = 23;
  localparam int PROD_W     = 23;  // 83 * c and 64 * (c0 +/- c2) fit 23 signed bits
  localparam int ODD_W      = 23;  // 83 * c1 + 36 * c3 stays under 2^22
  localparam int TOT_W      = 33;  // butterfly sum plus a rounding offset up to 2^30
  localparam int SHIFT_W    = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam int NUM_STAGES = 4;

  localparam logic [SHIFT_W-1:0] SHIFT_RESET = SHIFT_W'(7);
  localparam logic               CLIP_RESET  = 1'b1;

  localparam logic signed [TOT_W-1:0] CLIP_HI = TOT_W'(32767);
  localparam logic signed [TOT_W-1:0] CLIP_LO = -TOT_W'(32768);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SHIFT_AMOUNT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_CLIP_ENABLE  = CFG_IDX_W'(1);

  typedef logic signed [COEF_W-1:0] coef_t;
  typedef logic signed [RES_W-1:0]  res_t;
  typedef logic signed [TOT_W-1:0]  tot_t;

  // Settings applied by the output stage
  typedef struct packed {
    logic [SHIFT_W-1:0] shift;  // effective shift, never zero
    logic               clip;
  } fin_cfg_t;

endpackage

/* src/itx4_if.sv */
// Channel interfaces of the 4-point inverse transform: coefficient input,
// residual output and configuration write. Depends on itx4_pkg.
interface itx4_in_if;
  logic          valid;
  logic          ready;
  itx4_pkg::coef_t coef0;
  itx4_pkg::coef_t coef1;
  itx4_pkg::coef_t coef2;
  itx4_pkg::coef_t coef3;

  modport source (output valid, coef0, coef1, coef2, coef3, input ready);
  modport sink   (input valid, coef0, coef1, coef2, coef3, output ready);
endinterface

interface itx4_out_if;
  logic         valid;
  logic         ready;
  itx4_pkg::res_t res0;
  itx4_pkg::res_t res1;
  itx4_pkg::res_t res2;
  itx4_pkg::res_t res3;

  modport source (output valid, res0, res1, res2, res3, input ready);
  modport sink   (input valid, res0, res1, res2, res3, output ready);
endinterface

interface itx4_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [itx4_pkg::CFG_IDX_W-1:0]      index;
  logic [itx4_pkg::CFG_DATA_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* src/itx4_finish.sv */
// Output lane of the 4-point inverse transform: arithmetic right shift of
// the rounded sum and optional saturation to signed 16 bits. Uses itx4_pkg.
module itx4_finish (
  input  itx4_pkg::tot_t     tot,
  input  itx4_pkg::fin_cfg_t cfg,
  output itx4_pkg::res_t     res
);
  import itx4_pkg::*;

  tot_t shifted;
  tot_t limited;

  // Shift down, then saturate when clipping is on
  always_comb begin
    shifted = tot >>> cfg.shift;
    limited = shifted;
    if (cfg.clip) begin
      if (shifted > CLIP_HI) begin
        limited = CLIP_HI;
      end else if (shifted < CLIP_LO) begin
        limited = CLIP_LO;
      end
    end
  end

  assign res = limited[RES_W-1:0];

endmodule

/* src/inverse_transform_4_point.sv */
// Throughput: one request per cycle while out_res.ready is high; four register
// stages (products, odd terms, rounded butterfly sums, shift and clip) advance
// independently.
// Reset (rst_n low, synchronous): all stages empty, shift_amount 7, clip on.
// Configuration writes are taken every cycle (cfg ready is always high).
// Top level; depends on itx4_pkg, itx4_if and itx4_finish.
module inverse_transform_4_point (
  input logic        clk,
  input logic        rst_n,
  itx4_in_if.sink    in_req,
  itx4_out_if.source out_res,
  itx4_cfg_if.sink   cfg_wr
);
  import itx4_pkg::*;

  // Configuration registers
  logic [SHIFT_W-1:0] shift_r;
  logic               clip_r;
  fin_cfg_t           fin_cfg;
  tot_t               rnd;

  // Stage valids and per-stage ready
  logic [NUM_STAGES-1:0] vld_r;
  logic [NUM_STAGES-1:0] rdy;

  // Stage 1: products and even terms
  logic signed [PROD_W-1:0] p83c1_r, p36c1_r, p83c3_r, p36c3_r, e0_r, e1_r;
  logic signed [PROD_W-1:0] c1x_nxt, c3x_nxt;
  logic signed [COEF_W:0]   esum_nxt, edif_nxt;
  // Stage 2: odd terms, even terms carried along
  logic signed [ODD_W-1:0]  o0_r, o1_r;
  logic signed [PROD_W-1:0] e0b_r, e1b_r;
  // Stage 3: rounded butterfly sums
  tot_t tot0_r, tot1_r, tot2_r, tot3_r;
  // Stage 4: results
  res_t res0_nxt, res1_nxt, res2_nxt, res3_nxt;
  res_t res0_r, res1_r, res2_r, res3_r;

  // Write configuration; unknown indexes are dropped
  assign cfg_wr.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r <= SHIFT_RESET;
      clip_r  <= CLIP_RESET;
    end else if (cfg_wr.valid) begin
      if (cfg_wr.index == REG_SHIFT_AMOUNT) begin
        shift_r <= cfg_wr.data[SHIFT_W-1:0];
      end else if (cfg_wr.index == REG_CLIP_ENABLE) begin
        clip_r <= cfg_wr.data[0];
      end
    end
  end

  // A zero shift acts as a shift of one
  always_comb begin
    fin_cfg.shift = (shift_r == '0) ? SHIFT_W'(1) : shift_r;
    fin_cfg.clip  = clip_r;
    rnd           = TOT_W'(1) <<< (fin_cfg.shift - SHIFT_W'(1));
  end

  // Each stage advances when it is empty or the next one moves
  always_comb begin
    rdy[NUM_STAGES-1] = !vld_r[NUM_STAGES-1] || out_res.ready;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
  end

  assign in_req.ready = rdy[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (rdy[0]) begin
        vld_r[0] <= in_req.valid;
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (rdy[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  // Stage 1: constant multiplies and even butterfly
  always_comb begin
    c1x_nxt  = PROD_W'(in_req.coef1);
    c3x_nxt  = PROD_W'(in_req.coef3);
    esum_nxt = (COEF_W+1)'(in_req.coef0) + (COEF_W+1)'(in_req.coef2);
    edif_nxt = (COEF_W+1)'(in_req.coef0) - (COEF_W+1)'(in_req.coef2);
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      p83c1_r <= c1x_nxt * $signed(PROD_W'(83));
      p36c1_r <= c1x_nxt * $signed(PROD_W'(36));
      p83c3_r <= c3x_nxt * $signed(PROD_W'(83));
      p36c3_r <= c3x_nxt * $signed(PROD_W'(36));
      e0_r    <= PROD_W'(esum_nxt) <<< 6;
      e1_r    <= PROD_W'(edif_nxt) <<< 6;
    end
  end

  // Stage 2: odd terms
  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      o0_r  <= p83c1_r + p36c3_r;
      o1_r  <= p36c1_r - p83c3_r;
      e0b_r <= e0_r;
      e1b_r <= e1_r;
    end
  end

  // Stage 3: output butterfly with rounding offset
  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      tot0_r <= TOT_W'(e0b_r) + TOT_W'(o0_r) + rnd;
      tot1_r <= TOT_W'(e1b_r) + TOT_W'(o1_r) + rnd;
      tot2_r <= TOT_W'(e1b_r) - TOT_W'(o1_r) + rnd;
      tot3_r <= TOT_W'(e0b_r) - TOT_W'(o0_r) + rnd;
    end
  end

  // Stage 4: shift and clip each lane
  itx4_finish u_fin0 (.tot(tot0_r), .cfg(fin_cfg), .res(res0_nxt));
  itx4_finish u_fin1 (.tot(tot1_r), .cfg(fin_cfg), .res(res1_nxt));
  itx4_finish u_fin2 (.tot(tot2_r), .cfg(fin_cfg), .res(res2_nxt));
  itx4_finish u_fin3 (.tot(tot3_r), .cfg(fin_cfg), .res(res3_nxt));

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      res0_r <= res0_nxt;
      res1_r <= res1_nxt;
      res2_r <= res2_nxt;
      res3_r <= res3_nxt;
    end
  end

  assign out_res.valid = vld_r[NUM_STAGES-1];
  assign out_res.res0  = res0_r;
  assign out_res.res1  = res1_r;
  assign out_res.res2  = res2_r;
  assign out_res.res3  = res3_r;

  // A full pipe with a stalled output takes no new request
  a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (&vld_r && !out_res.ready) |-> !in_req.ready)
    else $error("request taken while pipeline full and stalled");

  // An item moves from stage 1 to stage 2 when stage 2 can take it
  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[0] && rdy[1]) |=> vld_r[1])
    else $error("stage 1 item lost");

  // Clipped results on lanes 0 and 3 stay within signed 16 bits
  a_clip_range: assert property (@(posedge clk) disable iff (!rst_n)
    (rdy[3] && vld_r[2] && fin_cfg.clip) |=>
      ($signed(res0_r) <= $signed(RES_W'(32767)) && $signed(res0_r) >= -$signed(RES_W'(32768))
       && $signed(res3_r) <= $signed(RES_W'(32767))
       && $signed(res3_r) >= -$signed(RES_W'(32768))))
    else $error("clipped result out of range");

  // A shift write lands in the shift register
  a_shift_wr: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_wr.valid && cfg_wr.ready && cfg_wr.index == REG_SHIFT_AMOUNT) |=>
      (shift_r == $past(cfg_wr.data[SHIFT_W-1:0])))
    else $error("shift_amount write not applied");

endmodule

/* tb/tb.sv */
// Self-checking bench for inverse_transform_4_point: directed corner columns, then
// random columns over several shift and clip settings, with random stalls on both sides.
// Depends on itx4_pkg, itx4_if and the block's RTL.
module tb;
  import itx4_pkg::*;

  localparam int    LATENCY    = 4;
  localparam int    MAX_SHOWN  = 10;
  localparam coef_t COEF_MAX   = coef_t'(32767);
  localparam coef_t COEF_MIN   = coef_t'(-32768);
  localparam longint SAT_HI    = 32767;
  localparam longint SAT_LO    = -32768;

  // Indexes that map to no register
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = CFG_IDX_W'(3);

  typedef struct packed {
    res_t r0;
    res_t r1;
    res_t r2;
    res_t r3;
  } res_row_t;

  logic clk;
  logic rst_n;

  itx4_in_if  in_req();
  itx4_out_if out_res();
  itx4_cfg_if cfg_wr();

  inverse_transform_4_point i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .out_res (out_res),
    .cfg_wr  (cfg_wr)
  );

  // Register copies used by the predictor
  logic [SHIFT_W-1:0] shift_cfg = SHIFT_RESET;
  logic               clip_cfg  = CLIP_RESET;

  res_row_t rows_due[$];
  int       error_count = 0;

  // Stall state for each side: each stretch is either free of stalls or has random ones
  int src_left  = 0;
  bit src_calm  = 1'b0;
  int sink_left = 0;
  bit sink_calm = 1'b0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int draw_wait(inout int left, inout bit calm);
    if (left == 0) begin
      calm = ($urandom_range(0, 2) == 0);
      left = $urandom_range(10, 60);
    end
    left--;
    return calm ? 0 : $urandom_range(0, 10);
  endfunction

  // Round, shift and optionally saturate one butterfly sum
  function automatic res_t round_shift(input longint sum);
    int unsigned s;
    longint      r;
    s = (shift_cfg == '0) ? 1 : int'(shift_cfg);
    r = (sum + (longint'(1) << (s - 1))) >>> s;
    if (clip_cfg) begin
      if (r > SAT_HI) r = SAT_HI;
      if (r < SAT_LO) r = SAT_LO;
    end
    return res_t'(r);
  endfunction

  function automatic res_row_t predict_row(input coef_t c0, c1, c2, c3);
    longint   odd0;
    longint   odd1;
    longint   even0;
    longint   even1;
    res_row_t row;
    odd0  = 83 * longint'(c1) + 36 * longint'(c3);
    odd1  = 36 * longint'(c1) - 83 * longint'(c3);
    even0 = 64 * longint'(c0) + 64 * longint'(c2);
    even1 = 64 * longint'(c0) - 64 * longint'(c2);
    row.r0 = round_shift(even0 + odd0);
    row.r1 = round_shift(even1 + odd1);
    row.r2 = round_shift(even1 - odd1);
    row.r3 = round_shift(even0 - odd0);
    return row;
  endfunction

  function automatic void report(input string msg);
    error_count++;
    if (error_count <= MAX_SHOWN) $display("%0t: %s", $realtime, msg);
  endfunction

  function automatic void check_field(input string name, input res_t want, input res_t got);
    if (got !== want)
      report($sformatf("%s mismatch: expected %0d, got %0d", name, want, got));
  endfunction

  // Compare each accepted result with the oldest prediction; queue a prediction per request
  always @(posedge clk) begin
    res_row_t want;
    if (rst_n) begin
      if (out_res.valid && out_res.ready) begin
        if (rows_due.size() == 0) begin
          report("result with no request outstanding");
        end else begin
          want = rows_due.pop_front();
          check_field("res0", want.r0, out_res.res0);
          check_field("res1", want.r1, out_res.res1);
          check_field("res2", want.r2, out_res.res2);
          check_field("res3", want.r3, out_res.res3);
        end
      end
      if (in_req.valid && in_req.ready)
        rows_due.push_back(predict_row(in_req.coef0, in_req.coef1, in_req.coef2, in_req.coef3));
    end
  end

  // Before each result, hold ready low for a random wait from draw_wait, which may be zero
  initial begin
    int k;
    out_res.ready = 1'b0;
    forever begin
      k = draw_wait(sink_left, sink_calm);
      @(negedge clk);
      if (k > 0) begin
        out_res.ready <= 1'b0;
        repeat (k) @(negedge clk);
      end
      out_res.ready <= 1'b1;
      do @(posedge clk); while (!(out_res.valid && out_res.ready));
    end
  end

  // Send one column; valid stays high after acceptance until the next call or drain_results
  task automatic send_column(input coef_t c0, c1, c2, c3);
    int gap;
    gap = draw_wait(src_left, src_calm);
    @(negedge clk);
    if (gap > 0) begin
      in_req.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_req.valid <= 1'b1;
    in_req.coef0 <= c0;
    in_req.coef1 <= c1;
    in_req.coef2 <= c2;
    in_req.coef3 <= c3;
    do @(posedge clk); while (!in_req.ready);
  endtask

  // Hold the input idle until every result is back and the pipeline is empty
  task automatic drain_results();
    @(negedge clk);
    in_req.valid <= 1'b0;
    while (rows_due.size() != 0) @(posedge clk);
    repeat (LATENCY + 2) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_wr.valid <= 1'b1;
    cfg_wr.index <= idx;
    cfg_wr.data  <= val;
    do @(posedge clk); while (!cfg_wr.ready);
    if (idx == REG_SHIFT_AMOUNT) shift_cfg = val[SHIFT_W-1:0];
    else if (idx == REG_CLIP_ENABLE) clip_cfg = val[0];
    @(negedge clk);
    cfg_wr.valid <= 1'b0;
  endtask

  // Write both registers; upper data bits are random and must be ignored
  task automatic set_mode(input logic [SHIFT_W-1:0] sh, input logic clip);
    write_reg(REG_SHIFT_AMOUNT, {3'($urandom), sh});
    write_reg(REG_CLIP_ENABLE, {7'($urandom), clip});
  endtask

  function automatic coef_t pick_coef();
    case ($urandom_range(0, 5))
      0: return COEF_MAX;
      1: return COEF_MIN;
      2: return coef_t'($urandom_range(0, 2)) - coef_t'(1);
      3: return coef_t'($urandom_range(0, 511)) - coef_t'(256);
      default: return coef_t'($urandom);
    endcase
  endfunction

  // Reset settings: saturation points and sign combinations
  task automatic test_extremes();
    send_column('0, '0, '0, '0);
    send_column(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX);
    send_column(COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN);
    send_column(COEF_MAX, COEF_MIN, COEF_MAX, COEF_MIN);
    send_column(COEF_MIN, COEF_MAX, COEF_MIN, COEF_MAX);
    send_column('0, COEF_MAX, '0, COEF_MIN);
    send_column('0, COEF_MIN, '0, COEF_MAX);
    send_column(COEF_MAX, '0, COEF_MIN, '0);
    drain_results();
  endtask

  // A shift of zero acts as a shift of one
  task automatic test_zero_shift();
    set_mode('0, 1'b1);
    send_column(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX);
    send_column(coef_t'(1), coef_t'(-1), '0, coef_t'(1));
    send_column(COEF_MIN, COEF_MAX, COEF_MAX, COEF_MIN);
    drain_results();
  endtask

  // A shift of 31 collapses every result to 0
  task automatic test_large_shift();
    set_mode(SHIFT_W'(31), 1'b1);
    send_column(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX);
    send_column(COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN);
    send_column(coef_t'(1), coef_t'(1), coef_t'(1), coef_t'(1));
    drain_results();
  endtask

  // Smallest shift without saturation reaches the widest results
  task automatic test_full_width();
    set_mode(SHIFT_W'(1), 1'b0);
    send_column(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX);
    send_column(COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN);
    send_column(COEF_MAX, COEF_MIN, COEF_MIN, COEF_MAX);
    send_column(COEF_MIN, COEF_MAX, COEF_MAX, COEF_MIN);
    drain_results();
  endtask

  // Writes to unmapped indexes must leave both registers alone
  task automatic test_spare_index();
    write_reg(REG_SPARE_2, '0);
    write_reg(REG_SPARE_3, '1);
    send_column(COEF_MAX, COEF_MIN, COEF_MAX, COEF_MIN);
    send_column(coef_t'(1000), coef_t'(-2000), coef_t'(3000), coef_t'(-4000));
    drain_results();
  endtask

  // Random columns under a series of settings, the extremes first
  task automatic test_random_columns();
    logic [SHIFT_W-1:0] sh;
    for (int phase = 0; phase < 10; phase++) begin
      case (phase)
        0: sh = SHIFT_W'(1);
        1: sh = SHIFT_W'(20);
        2: sh = '0;
        3: sh = SHIFT_W'(31);
        4: sh = SHIFT_W'(7);
        default: sh = SHIFT_W'($urandom_range(0, 31));
      endcase
      set_mode(sh, (phase < 4) ? phase[0] : 1'($urandom));
      if ($urandom_range(0, 2) == 0)
        write_reg($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3, CFG_DATA_W'($urandom));
      repeat (100) send_column(pick_coef(), pick_coef(), pick_coef(), pick_coef());
      drain_results();
    end
  endtask

  initial begin
    rst_n        = 1'b0;
    in_req.valid = 1'b0;
    in_req.coef0 = '0;
    in_req.coef1 = '0;
    in_req.coef2 = '0;
    in_req.coef3 = '0;
    cfg_wr.valid = 1'b0;
    cfg_wr.index = '0;
    cfg_wr.data  = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    repeat (2) @(negedge clk);

    test_extremes();
    test_zero_shift();
    test_large_shift();
    test_full_width();
    test_spare_index();
    test_random_columns();

    if (rows_due.size() != 0) report("results still outstanding at end of run");
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Abort a hung run
  initial begin
    #2400000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

/* files.f */
src/itx4_pkg.sv
src/itx4_if.sv
src/itx4_finish.sv
src/inverse_transform_4_point.sv
tb/tb.sv
